>>> design/assert_macros.svh
// Assertion macros used by the lock table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/ltm_pkg.sv
// Types, codes and helper functions of the lock table manager.
`default_nettype none

package ltm_pkg;

  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 4;
  localparam int MATRIX_BITS = 36;
  localparam logic [MATRIX_BITS-1:0] MATRIX_RESET = 36'd1126987775;
  localparam logic [MODE_BITS-1:0]   MODE_MAX     = 3'd5;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DUP_OWNED   = 4'd0,
    ST_DUP_PENDING = 4'd1,
    ST_GRANTED     = 4'd2,
    ST_QUEUED      = 4'd3,
    ST_REL_OWNED   = 4'd4,
    ST_REL_PENDING = 4'd5,
    ST_NOT_FOUND   = 4'd6,
    ST_NO_SLOT     = 4'd7,
    ST_LIST_FULL   = 4'd8,
    ST_PROMOTED    = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    OWN_WR_REQ,
    OWN_WR_CAND,
    OWN_WR_SHIFT
  } own_wsel_e;

  typedef enum logic {
    PEND_WR_REQ,
    PEND_WR_SHIFT
  } pend_wsel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_one;
    logic       key_chk;
    logic       set_hit;
    logic       alloc;
    logic       clr_ok;
    logic       chk_own;
    logic       use_cand;
    logic       cap_cand;
    logic       own_we;
    own_wsel_e  own_wsel;
    logic       pend_we;
    pend_wsel_e pend_wsel;
    logic       oc_inc;
    logic       oc_dec;
    logic       wc_inc;
    logic       wc_dec;
    logic       push;
    logic       push_cand;
    status_e    push_code;
    logic       fin;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic func;
    logic key_hit;
    logic idx_last_slot;
    logic free_vld;
    logic idx_at_oc;
    logic idx_at_wc;
    logic own_dup;
    logic own_tid;
    logic pend_dup;
    logic pend_tid;
    logic ok;
    logic oc_full;
    logic wc_zero;
    logic wc_full;
    logic out_free;
  } sts_t;

  // Requested mode req against held mode held; modes above MODE_MAX never fit
  function automatic logic compatible(input logic [MATRIX_BITS-1:0] matrix,
                                      input logic [MODE_BITS-1:0]   req,
                                      input logic [MODE_BITS-1:0]   held);
    logic [5:0] pos;
    logic       res;
    pos = {3'b000, req} * 6'd6 + {3'b000, held};
    res = 1'b0;
    if ((req <= MODE_MAX) && (held <= MODE_MAX)) begin
      res = matrix[pos];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/ltm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/ltm_ctrl.sv
// Sequencing state machine of the lock table manager.
`default_nettype none

module ltm_ctrl
  import ltm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_K_RD   = 5'd1;
  localparam logic [4:0] S_K_CMP  = 5'd2;
  localparam logic [4:0] S_MISS   = 5'd3;
  localparam logic [4:0] S_A_ORD  = 5'd4;
  localparam logic [4:0] S_A_OCMP = 5'd5;
  localparam logic [4:0] S_A_PRD  = 5'd6;
  localparam logic [4:0] S_A_PCMP = 5'd7;
  localparam logic [4:0] S_A_DEC  = 5'd8;
  localparam logic [4:0] S_R_ORD  = 5'd9;
  localparam logic [4:0] S_R_OCMP = 5'd10;
  localparam logic [4:0] S_R_PRD  = 5'd11;
  localparam logic [4:0] S_R_PCMP = 5'd12;
  localparam logic [4:0] S_OSH_RD = 5'd13;
  localparam logic [4:0] S_OSH_WR = 5'd14;
  localparam logic [4:0] S_PR_TOP = 5'd15;
  localparam logic [4:0] S_PR_RD  = 5'd16;
  localparam logic [4:0] S_PR_CAP = 5'd17;
  localparam logic [4:0] S_PC_RD  = 5'd18;
  localparam logic [4:0] S_PC_CMP = 5'd19;
  localparam logic [4:0] S_PR_DEC = 5'd20;
  localparam logic [4:0] S_PSH_RD = 5'd21;
  localparam logic [4:0] S_PSH_WR = 5'd22;
  localparam logic [4:0] S_FIN    = 5'd23;

  logic [4:0] state_q, state_d;
  logic       prom_q, prom_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Advance the state and the promotion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prom_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      prom_q  <= prom_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    prom_d  = prom_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_K_RD;
        end
      end
      S_K_RD: begin
        state_d = S_K_CMP;
      end
      S_K_CMP: begin
        cmd_o.key_chk = 1'b1;
        if (sts_i.key_hit) begin
          cmd_o.set_hit = 1'b1;
          cmd_o.clr_ok  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = sts_i.func ? S_R_ORD : S_A_ORD;
        end else if (sts_i.idx_last_slot) begin
          state_d = S_MISS;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_K_RD;
        end
      end
      S_MISS: begin
        if (sts_i.func || !sts_i.free_vld) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_code = sts_i.func ? ST_NOT_FOUND : ST_NO_SLOT;
            state_d         = S_FIN;
          end
        end else begin
          cmd_o.alloc   = 1'b1;
          cmd_o.clr_ok  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_A_ORD;
        end
      end
      // Acquire: scan owned list for a duplicate and for conflicts
      S_A_ORD: begin
        if (sts_i.idx_at_oc) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_A_PRD;
        end else begin
          state_d = S_A_OCMP;
        end
      end
      S_A_OCMP: begin
        cmd_o.chk_own = 1'b1;
        if (sts_i.own_dup) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_code = ST_DUP_OWNED;
            state_d         = S_FIN;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_A_ORD;
        end
      end
      // Acquire: scan pending list for a duplicate
      S_A_PRD: begin
        state_d = sts_i.idx_at_wc ? S_A_DEC : S_A_PCMP;
      end
      S_A_PCMP: begin
        if (sts_i.pend_dup) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_code = ST_DUP_PENDING;
            state_d         = S_FIN;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_A_PRD;
        end
      end
      // Acquire: queue, grant or refuse
      S_A_DEC: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_FIN;
          if (!sts_i.wc_zero || !sts_i.ok) begin
            if (sts_i.wc_full) begin
              cmd_o.push_code = ST_LIST_FULL;
            end else begin
              cmd_o.pend_we   = 1'b1;
              cmd_o.pend_wsel = PEND_WR_REQ;
              cmd_o.wc_inc    = 1'b1;
              cmd_o.push_code = ST_QUEUED;
            end
          end else if (sts_i.oc_full) begin
            cmd_o.push_code = ST_LIST_FULL;
          end else begin
            cmd_o.own_we    = 1'b1;
            cmd_o.own_wsel  = OWN_WR_REQ;
            cmd_o.oc_inc    = 1'b1;
            cmd_o.push_code = ST_GRANTED;
          end
        end
      end
      // Release: look for the transaction among the owners
      S_R_ORD: begin
        if (sts_i.idx_at_oc) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_R_PRD;
        end else begin
          state_d = S_R_OCMP;
        end
      end
      S_R_OCMP: begin
        cmd_o.idx_inc = 1'b1;
        state_d       = sts_i.own_tid ? S_OSH_RD : S_R_ORD;
      end
      // Release: look for the transaction among the waiters
      S_R_PRD: begin
        if (sts_i.idx_at_wc) begin
          if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_code = ST_NOT_FOUND;
            state_d         = S_FIN;
          end
        end else begin
          state_d = S_R_PCMP;
        end
      end
      S_R_PCMP: begin
        cmd_o.idx_inc = 1'b1;
        if (sts_i.pend_tid) begin
          prom_d  = 1'b0;
          state_d = S_PSH_RD;
        end else begin
          state_d = S_R_PRD;
        end
      end
      // Close the gap in the owned list
      S_OSH_RD: begin
        if (sts_i.idx_at_oc) begin
          if (sts_i.out_free) begin
            cmd_o.oc_dec    = 1'b1;
            cmd_o.push      = 1'b1;
            cmd_o.push_code = ST_REL_OWNED;
            state_d         = S_PR_TOP;
          end
        end else begin
          state_d = S_OSH_WR;
        end
      end
      S_OSH_WR: begin
        cmd_o.own_we   = 1'b1;
        cmd_o.own_wsel = OWN_WR_SHIFT;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_OSH_RD;
      end
      // Promote waiters from the head
      S_PR_TOP: begin
        if (sts_i.wc_zero || sts_i.oc_full) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_PR_RD;
        end
      end
      S_PR_RD: begin
        state_d = S_PR_CAP;
      end
      S_PR_CAP: begin
        cmd_o.cap_cand = 1'b1;
        cmd_o.clr_ok   = 1'b1;
        state_d        = S_PC_RD;
      end
      S_PC_RD: begin
        state_d = sts_i.idx_at_oc ? S_PR_DEC : S_PC_CMP;
      end
      S_PC_CMP: begin
        cmd_o.chk_own  = 1'b1;
        cmd_o.use_cand = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_PC_RD;
      end
      S_PR_DEC: begin
        if (!sts_i.ok) begin
          state_d = S_FIN;
        end else if (sts_i.out_free) begin
          cmd_o.own_we    = 1'b1;
          cmd_o.own_wsel  = OWN_WR_CAND;
          cmd_o.oc_inc    = 1'b1;
          cmd_o.push      = 1'b1;
          cmd_o.push_cand = 1'b1;
          cmd_o.push_code = ST_PROMOTED;
          cmd_o.idx_one   = 1'b1;
          prom_d          = 1'b1;
          state_d         = S_PSH_RD;
        end
      end
      // Close the gap in the pending list
      S_PSH_RD: begin
        if (sts_i.idx_at_wc) begin
          if (prom_q) begin
            cmd_o.wc_dec = 1'b1;
            state_d      = S_PR_TOP;
          end else if (sts_i.out_free) begin
            cmd_o.wc_dec    = 1'b1;
            cmd_o.push      = 1'b1;
            cmd_o.push_code = ST_REL_PENDING;
            state_d         = S_FIN;
          end
        end else begin
          state_d = S_PSH_WR;
        end
      end
      S_PSH_WR: begin
        cmd_o.pend_we   = 1'b1;
        cmd_o.pend_wsel = PEND_WR_SHIFT;
        cmd_o.idx_inc   = 1'b1;
        state_d         = S_PSH_RD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ltm_dp.sv
// Datapath of the lock table manager: tables, counters, compare logic and output stage.
`default_nettype none
`include "assert_macros.svh"

module ltm_dp
  import ltm_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int OWN_DEPTH  = 8,
  parameter int PEND_DEPTH = 8,
  parameter int TID_BITS   = 16,
  parameter int KEY_BITS   = 48
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [MATRIX_BITS-1:0] cfg_wdata_i,
  input  wire logic                   in_func_i,
  input  wire logic [TID_BITS-1:0]    in_tid_i,
  input  wire logic [KEY_BITS-1:0]    in_key_i,
  input  wire logic [MODE_BITS-1:0]   in_mode_i,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [STATUS_BITS-1:0]      out_status_o,
  output logic [TID_BITS-1:0]         out_who_o,
  output logic [MODE_BITS-1:0]        out_mode_o,
  output logic                        out_last_o
);

  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int MAXV0 = (OWN_DEPTH > PEND_DEPTH) ? OWN_DEPTH : PEND_DEPTH;
  localparam int MAXV  = (MAXV0 > NUM_SLOTS - 1) ? MAXV0 : NUM_SLOTS - 1;
  localparam int IW    = $clog2(MAXV + 1);
  localparam int OCW   = $clog2(OWN_DEPTH + 1);
  localparam int WCW   = $clog2(PEND_DEPTH + 1);
  localparam int OAW   = $clog2(NUM_SLOTS * OWN_DEPTH);
  localparam int PAW   = $clog2(NUM_SLOTS * PEND_DEPTH);
  localparam int LW    = TID_BITS + MODE_BITS;

  // Request and configuration
  logic                   req_func_q;
  logic [TID_BITS-1:0]    req_tid_q;
  logic [KEY_BITS-1:0]    req_key_q;
  logic [MODE_BITS-1:0]   req_mode_q;
  logic [MATRIX_BITS-1:0] matrix_q;

  // Slot bookkeeping
  logic [IW-1:0]        idx_q;
  logic [SW-1:0]        slot_q;
  logic                 slot_vld_q;
  logic [SW-1:0]        free_q;
  logic                 free_vld_q;
  logic [NUM_SLOTS-1:0] used_q;
  logic [OCW-1:0]       oc_q [NUM_SLOTS];
  logic [WCW-1:0]       wc_q [NUM_SLOTS];
  logic                 ok_q;
  logic [TID_BITS-1:0]  cand_tid_q;
  logic [MODE_BITS-1:0] cand_mode_q;

  // Result holding and output stage
  logic                   hold_vld_q;
  logic [STATUS_BITS-1:0] hold_status_q;
  logic [TID_BITS-1:0]    hold_who_q;
  logic [MODE_BITS-1:0]   hold_mode_q;
  logic                   out_vld_q;

  logic [SW-1:0]        idx_slot;
  logic [OCW-1:0]       oc_cur;
  logic [WCW-1:0]       wc_cur;
  logic [KEY_BITS-1:0]  key_rdata;
  logic [LW-1:0]        own_rdata, pend_rdata;
  logic [LW-1:0]        own_wdata, pend_wdata;
  logic [OAW-1:0]       own_base, own_raddr, own_waddr;
  logic [PAW-1:0]       pend_base, pend_raddr, pend_waddr;
  logic [TID_BITS-1:0]  own_rd_tid, pend_rd_tid;
  logic [MODE_BITS-1:0] own_rd_mode, pend_rd_mode, chk_mode;
  logic                 out_free;

  assign idx_slot = idx_q[SW-1:0];
  assign oc_cur   = oc_q[slot_q];
  assign wc_cur   = wc_q[slot_q];

  assign own_rd_tid   = own_rdata[TID_BITS-1:0];
  assign own_rd_mode  = own_rdata[LW-1 -: MODE_BITS];
  assign pend_rd_tid  = pend_rdata[TID_BITS-1:0];
  assign pend_rd_mode = pend_rdata[LW-1 -: MODE_BITS];

  // List addresses: slot base plus entry index
  assign own_base   = OAW'(OAW'(slot_q) * OAW'(OWN_DEPTH));
  assign own_raddr  = OAW'(own_base + OAW'(idx_q));
  assign pend_base  = PAW'(PAW'(slot_q) * PAW'(PEND_DEPTH));
  assign pend_raddr = PAW'(pend_base + PAW'(idx_q));

  always_comb begin
    case (cmd_i.own_wsel)
      OWN_WR_REQ: begin
        own_waddr = OAW'(own_base + OAW'(oc_cur));
        own_wdata = {req_mode_q, req_tid_q};
      end
      OWN_WR_CAND: begin
        own_waddr = OAW'(own_base + OAW'(oc_cur));
        own_wdata = {cand_mode_q, cand_tid_q};
      end
      OWN_WR_SHIFT: begin
        own_waddr = OAW'(own_raddr - OAW'(1));
        own_wdata = own_rdata;
      end
      default: begin
        own_waddr = OAW'(own_raddr - OAW'(1));
        own_wdata = own_rdata;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.pend_wsel)
      PEND_WR_REQ: begin
        pend_waddr = PAW'(pend_base + PAW'(wc_cur));
        pend_wdata = {req_mode_q, req_tid_q};
      end
      PEND_WR_SHIFT: begin
        pend_waddr = PAW'(pend_raddr - PAW'(1));
        pend_wdata = pend_rdata;
      end
      default: begin
        pend_waddr = PAW'(pend_raddr - PAW'(1));
        pend_wdata = pend_rdata;
      end
    endcase
  end

  ltm_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.alloc),
    .waddr_i (free_q),
    .wdata_i (req_key_q),
    .raddr_i (idx_slot),
    .rdata_o (key_rdata)
  );

  ltm_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS * OWN_DEPTH)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  ltm_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS * PEND_DEPTH)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  // Latch the request and capture the promotion candidate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q <= in_func_i;
      req_tid_q  <= in_tid_i;
      req_key_q  <= in_key_i;
      req_mode_q <= in_mode_i;
    end
    if (cmd_i.cap_cand) begin
      cand_tid_q  <= pend_rd_tid;
      cand_mode_q <= pend_rd_mode;
    end
  end

  // Hold the compatibility matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= MATRIX_RESET;
    end else if (cfg_we_i) begin
      matrix_q <= cfg_wdata_i;
    end
  end

  assign chk_mode = cmd_i.use_cand ? cand_mode_q : req_mode_q;

  // Index, slot selection, compatibility accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      slot_q     <= '0;
      slot_vld_q <= 1'b0;
      free_q     <= '0;
      free_vld_q <= 1'b0;
      ok_q       <= 1'b1;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_one) begin
        idx_q <= IW'(1);
      end else if (cmd_i.idx_inc) begin
        idx_q <= IW'(idx_q + IW'(1));
      end
      if (cmd_i.load) begin
        slot_vld_q <= 1'b0;
        free_vld_q <= 1'b0;
      end
      if (cmd_i.key_chk && !used_q[idx_slot] && !free_vld_q) begin
        free_q     <= idx_slot;
        free_vld_q <= 1'b1;
      end
      if (cmd_i.set_hit) begin
        slot_q     <= idx_slot;
        slot_vld_q <= 1'b1;
      end
      if (cmd_i.alloc) begin
        slot_q     <= free_q;
        slot_vld_q <= 1'b1;
      end
      if (cmd_i.clr_ok) begin
        ok_q <= 1'b1;
      end else if (cmd_i.chk_own) begin
        ok_q <= ok_q & compatible(matrix_q, chk_mode, own_rd_mode);
      end
    end
  end

  // Slot occupancy and list counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        oc_q[i] <= '0;
        wc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.alloc) begin
        used_q[free_q] <= 1'b1;
        oc_q[free_q]   <= '0;
        wc_q[free_q]   <= '0;
      end
      if (cmd_i.oc_inc) begin
        oc_q[slot_q] <= OCW'(oc_cur + OCW'(1));
      end else if (cmd_i.oc_dec) begin
        oc_q[slot_q] <= OCW'(oc_cur - OCW'(1));
      end
      if (cmd_i.wc_inc) begin
        wc_q[slot_q] <= WCW'(wc_cur + WCW'(1));
      end else if (cmd_i.wc_dec) begin
        wc_q[slot_q] <= WCW'(wc_cur - WCW'(1));
      end
      // Free the slot once both lists are empty
      if (cmd_i.fin && slot_vld_q && (oc_cur == '0) && (wc_cur == '0)) begin
        used_q[slot_q] <= 1'b0;
      end
    end
  end

  assign out_free = !out_vld_q || out_ready_i;

  // Output stage control: a held result goes out once the next one is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      if (cmd_i.fin || (cmd_i.push && hold_vld_q)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.push) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.fin) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      if (hold_vld_q) begin
        out_status_o <= hold_status_q;
        out_who_o    <= hold_who_q;
        out_mode_o   <= hold_mode_q;
        out_last_o   <= 1'b0;
      end
      hold_status_q <= cmd_i.push_code;
      hold_who_q    <= cmd_i.push_cand ? cand_tid_q : req_tid_q;
      hold_mode_q   <= cmd_i.push_cand ? cand_mode_q : req_mode_q;
    end
    if (cmd_i.fin) begin
      out_status_o <= hold_status_q;
      out_who_o    <= hold_who_q;
      out_mode_o   <= hold_mode_q;
      out_last_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;

  // Status toward the controller
  always_comb begin
    sts_o               = '0;
    sts_o.func          = req_func_q;
    sts_o.key_hit       = used_q[idx_slot] && (key_rdata == req_key_q);
    sts_o.idx_last_slot = (idx_q == IW'(NUM_SLOTS - 1));
    sts_o.free_vld      = free_vld_q;
    sts_o.idx_at_oc     = (idx_q == IW'(oc_cur));
    sts_o.idx_at_wc     = (idx_q == IW'(wc_cur));
    sts_o.own_tid       = (own_rd_tid == req_tid_q);
    sts_o.own_dup       = (own_rd_tid == req_tid_q) && (own_rd_mode == req_mode_q);
    sts_o.pend_tid      = (pend_rd_tid == req_tid_q);
    sts_o.pend_dup      = (pend_rd_tid == req_tid_q) && (pend_rd_mode == req_mode_q);
    sts_o.ok            = ok_q;
    sts_o.oc_full       = (oc_cur == OCW'(OWN_DEPTH));
    sts_o.wc_zero       = (wc_cur == '0);
    sts_o.wc_full       = (wc_cur == WCW'(PEND_DEPTH));
    sts_o.out_free      = out_free;
  end

  `ASSERT_PROP(a_push_room, (cmd_i.push || cmd_i.fin) |-> out_free, "result pushed into busy output")
  `ASSERT_PROP(a_fin_hold, cmd_i.fin |-> hold_vld_q, "request finished without a result")
  `ASSERT_NEVER(a_oc_over, slot_vld_q && (oc_cur > OCW'(OWN_DEPTH)), "owned count overflow")
  `ASSERT_NEVER(a_wc_over, slot_vld_q && (wc_cur > WCW'(PEND_DEPTH)), "pending count overflow")

endmodule

`default_nettype wire

>>> design/lock_table_manager_unit.sv
// Top level of the lock table manager: stream ports, controller and datapath.
//
// Lock table with a FIFO wait queue per resource. One request is processed at a time:
// the key search visits the slots in order and stops at the matching slot; each owned
// or pending entry looked at, moved or checked during promotion needs a read of the list
// memory's single read port, plus decision and hand-off steps. A release that promotes
// from a long pending list re-scans the owned list for each promotion. A stalled
// receiver holds up the work, since each result must leave the output register before
// the next one is produced. A release yields a released item followed by any
// promotions; every other request yields one item. The last result may wait in the
// output register while the next request is taken. No clearing pass is needed after
// reset.
`default_nettype none

module lock_table_manager_unit
  import ltm_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int OWN_DEPTH  = 8,
  parameter int PEND_DEPTH = 8,
  parameter int TID_BITS   = 16,
  parameter int KEY_BITS   = 48
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [MATRIX_BITS-1:0] cfg_wdata_i,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tdata: tid, resource, mode, zero padding
  input  wire logic [((TID_BITS+KEY_BITS+MODE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: func
  input  wire logic s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: who, held_mode, zero padding
  output logic [((TID_BITS+MODE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: status
  output logic [STATUS_BITS-1:0] m_axis_tuser,
  output logic m_axis_tlast
);

  localparam int OTW = ((TID_BITS + MODE_BITS + 7) / 8) * 8;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [TID_BITS-1:0]  out_who;
  logic [MODE_BITS-1:0] out_mode;

  ltm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ltm_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .OWN_DEPTH  (OWN_DEPTH),
    .PEND_DEPTH (PEND_DEPTH),
    .TID_BITS   (TID_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_func_i    (s_axis_tuser),
    .in_tid_i     (s_axis_tdata[TID_BITS-1:0]),
    .in_key_i     (s_axis_tdata[TID_BITS +: KEY_BITS]),
    .in_mode_i    (s_axis_tdata[TID_BITS+KEY_BITS +: MODE_BITS]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_who_o    (out_who),
    .out_mode_o   (out_mode),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = OTW'({out_mode, out_who});

endmodule

`default_nettype wire

>>> test/lock_table_manager_unit_test.sv
// Self-checking testbench for the lock table manager unit with a built-in lock table predictor.
`timescale 1ns / 1ps

module lock_table_manager_unit_test;
  import ltm_pkg::*;

  localparam int SLOTS = 16;
  localparam int OWN_D = 8;
  localparam int PEND_D = 8;
  localparam int KEYS = 20;

  typedef enum logic {OP_ACQUIRE = 1'b0, OP_RELEASE = 1'b1} op_e;

  typedef struct {
    op_e         op;
    logic [15:0] tid;
    logic [47:0] key;
    logic [2:0]  mode;
  } lock_req_t;

  typedef struct {
    status_e     st;
    logic [15:0] who;
    logic [2:0]  md;
    logic        last;
  } lock_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [MATRIX_BITS-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [STATUS_BITS-1:0] m_axis_tuser;
  logic m_axis_tlast;

  lock_table_manager_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #2ns clk_i = ~clk_i;

  // Shadow lock table
  logic [MATRIX_BITS-1:0] mtx;
  logic        slot_busy [SLOTS];
  logic [47:0] slot_res [SLOTS];
  logic [15:0] own_tid [SLOTS][OWN_D];
  logic [2:0]  own_md [SLOTS][OWN_D];
  int          own_n [SLOTS];
  logic [15:0] wait_tid [SLOTS][PEND_D];
  logic [2:0]  wait_md [SLOTS][PEND_D];
  int          wait_n [SLOTS];

  lock_req_t  req_q[$];
  lock_resp_t resp_q[$];
  lock_req_t  cur_req;
  logic [47:0] key_pool [KEYS];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  function automatic logic mode_fits(logic [2:0] req, logic [2:0] held);
    if (req > MODE_MAX || held > MODE_MAX) return 1'b0;
    return mtx[req * 6 + held];
  endfunction

  function automatic logic fits_owners(int s, logic [2:0] m);
    for (int i = 0; i < own_n[s]; i++)
      if (!mode_fits(m, own_md[s][i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_resp(status_e st, logic [15:0] who, logic [2:0] md);
    lock_resp_t r;
    r.st = st;
    r.who = who;
    r.md = md;
    r.last = 1'b0;
    resp_q.insert(resp_q.size(), r);
  endfunction

  // Apply one accepted request to the shadow table and queue its responses
  function automatic void predict_lock(lock_req_t q);
    int s;
    int i;
    s = -1;
    for (i = 0; i < SLOTS; i++)
      if (s < 0 && slot_busy[i] && slot_res[i] == q.key) s = i;
    if (q.op == OP_ACQUIRE) begin
      if (s < 0) begin
        for (i = 0; i < SLOTS; i++)
          if (s < 0 && !slot_busy[i]) s = i;
        if (s < 0) begin
          push_resp(ST_NO_SLOT, q.tid, q.mode);
        end else begin
          slot_busy[s] = 1'b1;
          slot_res[s] = q.key;
          own_n[s] = 0;
          wait_n[s] = 0;
        end
      end
      if (s >= 0) begin
        status_e st;
        st = ST_GRANTED;
        for (i = 0; i < own_n[s]; i++)
          if (own_tid[s][i] == q.tid && own_md[s][i] == q.mode) st = ST_DUP_OWNED;
        if (st == ST_GRANTED)
          for (i = 0; i < wait_n[s]; i++)
            if (wait_tid[s][i] == q.tid && wait_md[s][i] == q.mode) st = ST_DUP_PENDING;
        if (st == ST_GRANTED) begin
          if (wait_n[s] > 0 || !fits_owners(s, q.mode)) begin
            if (wait_n[s] >= PEND_D) begin
              st = ST_LIST_FULL;
            end else begin
              wait_tid[s][wait_n[s]] = q.tid;
              wait_md[s][wait_n[s]] = q.mode;
              wait_n[s]++;
              st = ST_QUEUED;
            end
          end else if (own_n[s] >= OWN_D) begin
            st = ST_LIST_FULL;
          end else begin
            own_tid[s][own_n[s]] = q.tid;
            own_md[s][own_n[s]] = q.mode;
            own_n[s]++;
          end
        end
        push_resp(st, q.tid, q.mode);
      end
    end else if (s < 0) begin
      push_resp(ST_NOT_FOUND, q.tid, q.mode);
    end else begin
      int hit;
      hit = -1;
      for (i = 0; i < own_n[s]; i++)
        if (hit < 0 && own_tid[s][i] == q.tid) hit = i;
      if (hit >= 0) begin
        for (i = hit + 1; i < own_n[s]; i++) begin
          own_tid[s][i-1] = own_tid[s][i];
          own_md[s][i-1] = own_md[s][i];
        end
        own_n[s]--;
        push_resp(ST_REL_OWNED, q.tid, q.mode);
        // Promote waiters from the head while they fit
        while (wait_n[s] > 0 && own_n[s] < OWN_D && fits_owners(s, wait_md[s][0])) begin
          own_tid[s][own_n[s]] = wait_tid[s][0];
          own_md[s][own_n[s]] = wait_md[s][0];
          own_n[s]++;
          push_resp(ST_PROMOTED, wait_tid[s][0], wait_md[s][0]);
          for (i = 1; i < wait_n[s]; i++) begin
            wait_tid[s][i-1] = wait_tid[s][i];
            wait_md[s][i-1] = wait_md[s][i];
          end
          wait_n[s]--;
        end
      end else begin
        for (i = 0; i < wait_n[s]; i++)
          if (hit < 0 && wait_tid[s][i] == q.tid) hit = i;
        if (hit >= 0) begin
          for (i = hit + 1; i < wait_n[s]; i++) begin
            wait_tid[s][i-1] = wait_tid[s][i];
            wait_md[s][i-1] = wait_md[s][i];
          end
          wait_n[s]--;
          push_resp(ST_REL_PENDING, q.tid, q.mode);
        end else begin
          push_resp(ST_NOT_FOUND, q.tid, q.mode);
        end
      end
      if (own_n[s] == 0 && wait_n[s] == 0) slot_busy[s] = 1'b0;
    end
    resp_q[resp_q.size()-1].last = 1'b1;
  endfunction

  // Request driver: predict on each transfer, then offer the next request or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_lock(cur_req);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current offer
      end else if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        cur_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, cur_req.mode, cur_req.key, cur_req.tid};
        s_axis_tuser <= cur_req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (resp_q.size() == 0) begin
        $display("%t unexpected result: status %0d who %h mode %0d last %b", $realtime,
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tlast);
        errors++;
      end else begin
        lock_resp_t e;
        e = resp_q.pop_front();
        if (m_axis_tuser !== e.st || m_axis_tdata[15:0] !== e.who ||
            m_axis_tdata[18:16] !== e.md || m_axis_tlast !== e.last) begin
          $display("%t mismatch: expected status %0d who %h mode %0d last %b", $realtime,
                   e.st, e.who, e.md, e.last);
          $display("%t           actual   status %0d who %h mode %0d last %b", $realtime,
                   m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[18:16], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  task automatic add_req(op_e op, logic [15:0] tid, logic [47:0] key, logic [2:0] mode);
    lock_req_t q;
    q.op = op;
    q.tid = tid;
    q.key = key;
    q.mode = mode;
    req_q.insert(req_q.size(), q);
  endtask

  task automatic drain();
    while (req_q.size() > 0 || s_axis_tvalid || resp_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_matrix(logic [MATRIX_BITS-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    mtx = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int snd, int rcv);
    @(posedge clk_i);
    send_idle <= snd;
    recv_stall <= rcv;
  endtask

  // Mostly acquire/release traffic on a few hot keys with a small set of transactions
  task automatic add_random(int n);
    logic [15:0] tid;
    logic [2:0]  md;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      tid = 16'($urandom_range(0, 7)) ^ (($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'h0);
      md = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if (r < 5)
        add_req(op_e'($urandom_range(0, 1)), 16'($urandom), {16'($urandom), 32'($urandom)},
                3'($urandom));
      else if (r < 58)
        add_req(OP_ACQUIRE, tid, key_pool[$urandom_range(0, r < 50 ? 3 : KEYS-1)], md);
      else
        add_req(OP_RELEASE, tid, key_pool[$urandom_range(0, r < 95 ? 3 : KEYS-1)], md);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEYS; i++) key_pool[i] = {8'($urandom), 32'($urandom), 8'(i)};
    mtx = MATRIX_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      own_n[i] = 0;
      wait_n[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_matrix(MATRIX_RESET);

    // Directed: grant, duplicates, queue, release paths, odd modes, full lists
    add_req(OP_ACQUIRE, 16'h0000, key_pool[0], 3'd5);
    add_req(OP_ACQUIRE, 16'h0000, key_pool[0], 3'd5);
    add_req(OP_ACQUIRE, 16'hFFFF, key_pool[0], 3'd3);
    add_req(OP_ACQUIRE, 16'hFFFF, key_pool[0], 3'd3);
    add_req(OP_RELEASE, 16'hFFFF, key_pool[0], 3'd7);
    add_req(OP_ACQUIRE, 16'hFFFF, key_pool[0], 3'd3);
    add_req(OP_ACQUIRE, 16'h0001, key_pool[0], 3'd1);
    add_req(OP_RELEASE, 16'h0000, key_pool[0], 3'd0);
    add_req(OP_RELEASE, 16'h0005, key_pool[0], 3'd0);
    add_req(OP_RELEASE, 16'h0005, key_pool[1], 3'd0);
    add_req(OP_ACQUIRE, 16'h0002, key_pool[1], 3'd6);
    add_req(OP_ACQUIRE, 16'h0003, key_pool[1], 3'd7);
    add_req(OP_RELEASE, 16'h0002, key_pool[1], 3'd0);
    for (int i = 0; i < 9; i++) add_req(OP_ACQUIRE, 16'(i + 16), key_pool[2], 3'd0);
    drain();

    // Exhaust the slots, then free them again
    for (int i = 3; i < KEYS; i++) add_req(OP_ACQUIRE, 16'h0042, key_pool[i], 3'd4);
    for (int i = 3; i < KEYS; i++) add_req(OP_RELEASE, 16'h0042, key_pool[i], 3'd4);
    drain();

    // Phase: permissive matrix, no idling
    write_matrix('1);
    set_idling(0, 0);
    add_random(12);
    drain();

    // Phase: nothing compatible, sender mostly idle; fills pending lists
    write_matrix('0);
    set_idling(68, 0);
    add_random(12);
    drain();

    // Phase: random matrix, receiver stalls, long hold-off while requests keep coming
    write_matrix({4'($urandom), 32'($urandom)});
    set_idling(0, 68);
    add_random(10);
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    add_random(10);
    drain();

    // Phase: default matrix, both sides idle; sender pauses until all results are in
    write_matrix(MATRIX_RESET);
    set_idling(33, 33);
    add_random(8);
    drain();
    add_random(8);
    drain();
    set_idling(0, 0);
    add_random(8);
    drain();

    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
